// ----- design/utc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the utf-8 text console cursor
package utc_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int COL_W   = 8;
    localparam int ROW_W   = 6;
    localparam int COLS_W  = 9;
    localparam int ROWS_W  = 6;
    localparam int PEND_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COLS_W-1:0] cols_t;
    typedef logic [ROWS_W-1:0] rows_t;
    typedef logic [PEND_W-1:0] pend_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 1'd1;

    localparam cols_t COLS_RESET = 9'd32;
    localparam rows_t ROWS_RESET = 6'd6;

    // command kinds
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    // special code points
    localparam cp_t CP_REPLACEMENT = 21'h00FFFD;
    localparam cp_t CP_NEWLINE     = 21'd10;
    localparam cp_t CP_RETURN      = 21'd13;

    // byte classification masks
    localparam byte_t CONT_MASK  = 8'hC0;
    localparam byte_t CONT_PAT   = 8'h80;
    localparam byte_t LEAD4_MASK = 8'hF8;
    localparam byte_t LEAD4_PAT  = 8'hF0;
    localparam byte_t LEAD3_MASK = 8'hF0;
    localparam byte_t LEAD3_PAT  = 8'hE0;
    localparam byte_t LEAD2_MASK = 8'hE0;
    localparam byte_t LEAD2_PAT  = 8'hC0;

    localparam col_t COL_LAST = 8'd255;

    // console geometry as held in the configuration registers
    typedef struct packed {
        cols_t text_columns;
        rows_t text_rows;
    } cfg_t;

endpackage

// ----- design/utc_byte_if.sv -----
`timescale 1ns / 1ps
// byte channel interface
interface utc_byte_if;
    import utc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

// ----- design/utc_cmd_if.sv -----
`timescale 1ns / 1ps
// command channel interface
interface utc_cmd_if;
    import utc_pkg::*;

    logic valid;
    logic ready;
    logic command_kind;
    col_t cell_column;
    row_t cell_row;
    cp_t  code_point;
    logic last_of_run;

    modport source (output valid, output command_kind, output cell_column,
                    output cell_row, output code_point, output last_of_run,
                    input ready);
    modport sink (input valid, input command_kind, input cell_column,
                  input cell_row, input code_point, input last_of_run,
                  output ready);
endinterface

// ----- design/utf8_text_console_cursor.sv -----
`timescale 1ns / 1ps
// top level of the utf-8 text console cursor
//
//   channel   | dir | beat content
//   ----------+-----+------------------------------------------------------
//   text_in   | in  | text_byte: one raw byte of the utf-8 stream
//   cmd_out   | out | command_kind, cell_column, cell_row, code_point,
//             |     | last_of_run
//   cfg       | in  | cfg_we, cfg_index, cfg_data: geometry register write
//
// one byte is taken per cycle; a command leaves through the code point queue
// and the output register. a draw that wraps past the last row is followed
// by its trailing scroll, absorbed by the 4-entry code point queue.
// reset clears decoder state, cursor, queue and output valid, and loads
// 32 columns by 6 rows. input stalls only when the queue is full.
module utf8_text_console_cursor (
    input  logic                                clk,
    input  logic                                rst_n,
    utc_byte_if.sink                            text_in,
    utc_cmd_if.source                           cmd_out,
    input  logic                                cfg_we,
    input  logic [utc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [utc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import utc_pkg::*;

    cfg_t cfg_reg;
    logic push;
    cp_t  push_cp;
    logic queue_full;
    logic pop;
    logic not_empty;
    cp_t  head_cp;

    // geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_columns <= COLS_RESET;
            cfg_reg.text_rows    <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEXT_COLUMNS: cfg_reg.text_columns <= cfg_data[COLS_W-1:0];
                REG_TEXT_ROWS:    cfg_reg.text_rows    <= cfg_data[ROWS_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    utc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .push       (push),
        .push_cp    (push_cp),
        .queue_full (queue_full)
    );

    utc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cp   (push_cp),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cp   (head_cp)
    );

    utc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .not_empty (not_empty),
        .head_cp   (head_cp),
        .pop       (pop),
        .cmd_out   (cmd_out)
    );

endmodule

// ----- design/utc_front.sv -----
`timescale 1ns / 1ps
// utf-8 decoder front: takes bytes and pushes decoded code points
module utc_front (
    input  logic           clk,
    input  logic           rst_n,
    utc_byte_if.sink       text_in,
    output logic           push,
    output utc_pkg::cp_t   push_cp,
    input  logic           queue_full
);
    import utc_pkg::*;

    cp_t   partial_reg;
    cp_t   partial_next;
    pend_t pending_reg;
    pend_t pending_next;
    logic  emit;
    logic  accept;
    byte_t b;

    assign b             = text_in.text_byte;
    assign text_in.ready = !queue_full;
    assign accept        = text_in.valid && text_in.ready;
    assign push          = accept && emit;

    // byte classification and code point assembly
    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        emit         = 1'b0;
        push_cp      = cp_t'(b);
        if (pending_reg != '0)
        begin
            if ((b & CONT_MASK) == CONT_PAT)
            begin
                partial_next = {partial_reg[CP_W-7:0], b[5:0]};
                pending_next = pending_reg - 2'd1;
                emit         = (pending_reg == 2'd1);
                push_cp      = partial_next;
            end
            else
            begin
                // broken sequence: replacement char, offending byte dropped
                pending_next = '0;
                emit         = 1'b1;
                push_cp      = CP_REPLACEMENT;
            end
        end
        else if ((b & LEAD4_MASK) == LEAD4_PAT)
        begin
            partial_next = cp_t'(b[2:0]);
            pending_next = 2'd3;
        end
        else if ((b & LEAD3_MASK) == LEAD3_PAT)
        begin
            partial_next = cp_t'(b[3:0]);
            pending_next = 2'd2;
        end
        else if ((b & LEAD2_MASK) == LEAD2_PAT)
        begin
            partial_next = cp_t'(b[4:0]);
            pending_next = 2'd1;
        end
        else
        begin
            emit = 1'b1;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= '0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- design/utc_queue.sv -----
`timescale 1ns / 1ps
// short code point queue between decoder and cursor logic
module utc_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  utc_pkg::cp_t push_cp,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output utc_pkg::cp_t head_cp
);
    import utc_pkg::*;

    cp_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cp   = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cp;
    end

endmodule

// ----- design/utc_back.sv -----
`timescale 1ns / 1ps
// cursor logic: turns code points into draw and scroll commands
module utc_back (
    input  logic         clk,
    input  logic         rst_n,
    input  utc_pkg::cfg_t cfg,
    input  logic         not_empty,
    input  utc_pkg::cp_t head_cp,
    output logic         pop,
    utc_cmd_if.source    cmd_out
);
    import utc_pkg::*;

    col_t col_reg;
    col_t col_next;
    row_t row_reg;
    row_t row_next;
    logic scroll_pend_reg;
    logic scroll_pend_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic load;
    logic kind_next;
    col_t ocol_next;
    row_t orow_next;
    cp_t  ocp_next;
    logic last_next;
    logic kind_reg;
    col_t ocol_reg;
    row_t orow_reg;
    cp_t  ocp_reg;
    logic last_reg;
    logic slot_free;
    logic row_full;
    logic col_wrap;

    assign slot_free = !out_valid_reg || cmd_out.ready;
    assign pop       = not_empty && !scroll_pend_reg && slot_free;
    assign row_full  = ({1'b0, row_reg} + 7'd1) >= {1'b0, cfg.text_rows};
    assign col_wrap  = (({1'b0, col_reg} + 9'd1) >= cfg.text_columns)
                       || (col_reg == COL_LAST);

    // cursor update and command selection
    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        scroll_pend_next = scroll_pend_reg;
        out_valid_next   = out_valid_reg && !cmd_out.ready;
        load             = 1'b0;
        kind_next        = CMD_SCROLL;
        ocol_next        = '0;
        orow_next        = '0;
        ocp_next         = '0;
        last_next        = 1'b1;
        if (scroll_pend_reg && slot_free)
        begin
            // scroll that trails a wrapping draw
            load             = 1'b1;
            scroll_pend_next = 1'b0;
        end
        else if (pop)
        begin
            if (head_cp == CP_NEWLINE)
            begin
                col_next = '0;
                if (row_full)
                    load = 1'b1;
                else
                    row_next = row_reg + 1'b1;
            end
            else if (head_cp == CP_RETURN)
            begin
                col_next = '0;
            end
            else
            begin
                load      = 1'b1;
                kind_next = CMD_DRAW;
                ocol_next = col_reg;
                orow_next = row_reg;
                ocp_next  = head_cp;
                if (col_wrap)
                begin
                    col_next = '0;
                    if (row_full)
                    begin
                        last_next        = 1'b0;
                        scroll_pend_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
        if (load)
            out_valid_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            scroll_pend_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            scroll_pend_reg <= scroll_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            ocp_reg  <= ocp_next;
            last_reg <= last_next;
        end
    end

    assign cmd_out.valid        = out_valid_reg;
    assign cmd_out.command_kind = kind_reg;
    assign cmd_out.cell_column  = ocol_reg;
    assign cmd_out.cell_row     = orow_reg;
    assign cmd_out.code_point   = ocp_reg;
    assign cmd_out.last_of_run  = last_reg;

endmodule

// ----- dv/utf8_text_console_cursor_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the utf-8 text console cursor: directed table, then random phases
module utf8_text_console_cursor_test;
    import utc_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 8;
    localparam int PHASES       = 9;
    localparam int LONG_PHASE   = 3;
    localparam int PHASE_ITEMS  = 50;
    localparam int LONG_ITEMS   = 330;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;

    // one command beat as it leaves the block
    typedef struct packed {
        logic kind;
        col_t col;
        row_t row;
        cp_t  cp;
        logic last;
    } cmd_beat_t;

    // one byte of stimulus, with an optional typed-in expectation
    typedef struct packed {
        byte_t     b;
        logic      typed;
        logic      typed_n;
        cmd_beat_t beat;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    utc_byte_if text_ch ();
    utc_cmd_if  cmd_ch ();

    utf8_text_console_cursor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_ch.sink),
        .cmd_out   (cmd_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    cols_t geom_cols = COLS_RESET;
    rows_t geom_rows = ROWS_RESET;
    col_t  pred_col = '0;
    row_t  pred_row = '0;
    cp_t   seq_code = '0;
    pend_t seq_left = '0;

    cmd_beat_t placed[$];
    cmd_beat_t commands_due[$];
    stim_row_t byte_backlog[$];
    stim_row_t directed_rows[$];

    int  bytes_queued = 0;
    int  bytes_accepted = 0;
    int  errors = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    bit  hold_done = 1'b0;

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT)
            @(posedge clk);
        $display("utf8_text_console_cursor regression: fail");
        $finish;
    end

    function automatic stim_row_t plain_row(byte_t b);
        stim_row_t r;
        r = '0;
        r.b = b;
        return r;
    endfunction

    // typed draw expectation, or typed silence when n is 0
    function automatic stim_row_t drawn_row(byte_t b, logic n, int col, int row, cp_t cp);
        stim_row_t r;
        r = '0;
        r.b = b;
        r.typed = 1'b1;
        r.typed_n = n;
        r.beat.kind = CMD_DRAW;
        r.beat.col = col_t'(col);
        r.beat.row = row_t'(row);
        r.beat.cp = cp;
        r.beat.last = 1'b1;
        return r;
    endfunction

    // row advance; returns 1 when the console must scroll instead
    function automatic bit next_row_scrolls();
        if (int'(pred_row) + 1 >= int'(geom_rows))
            return 1'b1;
        pred_row = pred_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_scroll();
        cmd_beat_t s;
        s = '0;
        s.kind = CMD_SCROLL;
        placed.push_back(s);
    endfunction

    // decode one byte and place the resulting commands
    function automatic void place_byte(byte_t b);
        cp_t       cp;
        bit        emit;
        cmd_beat_t d;
        placed.delete();
        emit = 1'b1;
        cp = '0;
        if (seq_left != 0)
        begin
            if ((b & CONT_MASK) == CONT_PAT)
            begin
                seq_code = {seq_code[CP_W-7:0], b[5:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left != 0)
                    emit = 1'b0;
                cp = seq_code;
            end
            else
            begin
                seq_left = '0;
                cp = CP_REPLACEMENT;
            end
        end
        else if ((b & LEAD4_MASK) == LEAD4_PAT)
        begin
            seq_code = cp_t'(b[2:0]);
            seq_left = 2'd3;
            emit = 1'b0;
        end
        else if ((b & LEAD3_MASK) == LEAD3_PAT)
        begin
            seq_code = cp_t'(b[3:0]);
            seq_left = 2'd2;
            emit = 1'b0;
        end
        else if ((b & LEAD2_MASK) == LEAD2_PAT)
        begin
            seq_code = cp_t'(b[4:0]);
            seq_left = 2'd1;
            emit = 1'b0;
        end
        else
            cp = cp_t'(b);

        if (emit)
        begin
            if (cp == CP_NEWLINE)
            begin
                pred_col = '0;
                if (next_row_scrolls())
                    push_scroll();
            end
            else if (cp == CP_RETURN)
                pred_col = '0;
            else
            begin
                d = '0;
                d.kind = CMD_DRAW;
                d.col = pred_col;
                d.row = pred_row;
                d.cp = cp;
                placed.push_back(d);
                if (int'(pred_col) + 1 >= int'(geom_cols) || pred_col == COL_LAST)
                begin
                    pred_col = '0;
                    if (next_row_scrolls())
                        push_scroll();
                end
                else
                    pred_col = pred_col + 1'b1;
            end
        end
        if (placed.size() > 0)
            placed[placed.size()-1].last = 1'b1;
    endfunction

    // accepted byte: advance the predictor and queue what is due
    function automatic void take_byte(stim_row_t r);
        place_byte(r.b);
        if (r.typed)
        begin
            if (r.typed_n)
                commands_due.push_back(r.beat);
        end
        else
            foreach (placed[i])
                commands_due.push_back(placed[i]);
    endfunction

    function automatic void queue_byte(byte_t b);
        byte_backlog.push_back(plain_row(b));
        bytes_queued++;
    endfunction

    function automatic byte_t cont_byte();
        return 8'h80 | byte_t'($urandom_range(0, 63));
    endfunction

    function automatic byte_t lead_byte(int len);
        if (len == 2)
            return 8'hC0 | byte_t'($urandom_range(0, 31));
        if (len == 3)
            return 8'hE0 | byte_t'($urandom_range(0, 15));
        return 8'hF0 | byte_t'($urandom_range(0, 7));
    endfunction

    // random text: mostly well-formed sequences, some broken ones and raw noise
    task automatic queue_random(int count, bit long_line);
        int start;
        int pick;
        int len;
        int k;
        int nb;
        start = bytes_queued;
        while (bytes_queued - start < count)
        begin
            pick = $urandom_range(0, 15);
            if (long_line)
                pick = (pick <= 10) ? 0 : pick - 4;
            case (pick)
                0, 1, 2, 3, 4: queue_byte(byte_t'($urandom_range(8'h20, 8'h7E)));
                5: queue_byte(8'h0A);
                6: queue_byte(8'h0D);
                7, 8, 9:
                begin
                    len = pick - 5;
                    queue_byte(lead_byte(len));
                    for (k = 1; k < len; k++)
                        queue_byte(cont_byte());
                end
                10:
                begin
                    len = $urandom_range(2, 4);
                    queue_byte(lead_byte(len));
                    for (k = $urandom_range(0, len - 2); k > 0; k--)
                        queue_byte(cont_byte());
                    nb = $urandom_range(0, 191);
                    if (nb >= 128)
                        nb += 64;
                    queue_byte(byte_t'(nb));
                end
                11:
                begin
                    // overlong newline or carriage return
                    queue_byte(8'hC0);
                    queue_byte($urandom_range(0, 1) ? 8'h8A : 8'h8D);
                end
                default: queue_byte(byte_t'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // wait for every byte to be taken and every command to come, up to DRAIN_LIMIT, then settle
    task automatic drain();
        int guard;
        while (bytes_accepted != bytes_queued)
            @(posedge clk);
        guard = 0;
        while (commands_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_geometry(int cols, int rows);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_TEXT_COLUMNS;
        cfg_data <= CFG_DATA_W'(cols);
        geom_cols = cols_t'(cols);
        @(posedge clk);
        cfg_index <= REG_TEXT_ROWS;
        cfg_data <= CFG_DATA_W'(rows);
        geom_rows = rows_t'(rows);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // byte sender with random idle bursts
    initial
    begin
        stim_row_t in_flight;
        int        send_gap;
        send_gap = 0;
        in_flight = '0;
        text_ch.valid <= 1'b0;
        text_ch.text_byte <= '0;
        forever
        begin
            @(posedge clk);
            if (text_ch.valid && text_ch.ready)
            begin
                take_byte(in_flight);
                bytes_accepted++;
            end
            if (!text_ch.valid || text_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    text_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 12) - 1;
                    text_ch.valid <= 1'b0;
                end
                else if (byte_backlog.size() > 0)
                begin
                    in_flight = byte_backlog.pop_front();
                    text_ch.valid <= 1'b1;
                    text_ch.text_byte <= in_flight.b;
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end
    end

    // compare one command beat against the oldest one due
    function automatic void check_command();
        cmd_beat_t want;
        if (commands_due.size() == 0)
        begin
            $error("unexpected command beat: kind %0d col %0d row %0d cp %h",
                   cmd_ch.command_kind, cmd_ch.cell_column, cmd_ch.cell_row,
                   cmd_ch.code_point);
            errors++;
            return;
        end
        want = commands_due.pop_front();
        if (cmd_ch.command_kind !== want.kind)
        begin
            $error("command_kind expected %0d got %0d", want.kind, cmd_ch.command_kind);
            errors++;
        end
        if (cmd_ch.cell_column !== want.col)
        begin
            $error("cell_column expected %0d got %0d", want.col, cmd_ch.cell_column);
            errors++;
        end
        if (cmd_ch.cell_row !== want.row)
        begin
            $error("cell_row expected %0d got %0d", want.row, cmd_ch.cell_row);
            errors++;
        end
        if (cmd_ch.code_point !== want.cp)
        begin
            $error("code_point expected %h got %h", want.cp, cmd_ch.code_point);
            errors++;
        end
        if (cmd_ch.last_of_run !== want.last)
        begin
            $error("last_of_run expected %0d got %0d", want.last, cmd_ch.last_of_run);
            errors++;
        end
    endfunction

    // command receiver with random stalls and one long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        cmd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cmd_ch.valid && cmd_ch.ready)
                check_command();
            if (!hold_done && bytes_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cmd_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                cmd_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                cmd_ch.ready <= 1'b0;
            end
            else
                cmd_ch.ready <= 1'b1;
        end
    end

    // main sequence
    initial
    begin
        int cols_plan [PHASES];
        int rows_plan [PHASES];
        int p;
        cols_plan = '{1, 256, 2, 256, 1, 17, 80, 3, 0};
        rows_plan = '{1, 48, 1, 2, 48, 5, 3, 47, 0};
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table at reset geometry, 32 columns by 6 rows
        directed_rows = '{
            drawn_row(8'h41, 1'b1, 0, 0, 21'h000041),
            drawn_row(8'h00, 1'b1, 1, 0, 21'h000000),
            drawn_row(8'hFF, 1'b1, 2, 0, 21'h0000FF),
            drawn_row(8'h80, 1'b1, 3, 0, 21'h000080),
            drawn_row(8'hC3, 1'b0, 0, 0, 21'h0),
            plain_row(8'hA9),
            plain_row(8'hE2), plain_row(8'h82), plain_row(8'hAC),
            plain_row(8'hF0), plain_row(8'h9F), plain_row(8'h98), plain_row(8'h80),
            // lead broken off by a plain byte: replacement, byte dropped
            plain_row(8'hC3),
            drawn_row(8'h41, 1'b1, 7, 0, CP_REPLACEMENT),
            // lead broken off by newline: the newline is dropped too
            plain_row(8'hE2),
            drawn_row(8'h0A, 1'b1, 8, 0, CP_REPLACEMENT),
            drawn_row(8'h0D, 1'b0, 0, 0, 21'h0),
            drawn_row(8'h0A, 1'b0, 0, 0, 21'h0),
            // decoded newline acts as newline
            plain_row(8'hC0), plain_row(8'h8A),
            // largest code point, then a stray byte above the lead range
            plain_row(8'hF7), plain_row(8'hBF), plain_row(8'hBF), plain_row(8'hBF),
            plain_row(8'hF8)
        };
        foreach (directed_rows[i])
        begin
            byte_backlog.push_back(directed_rows[i]);
            bytes_queued++;
        end
        drain();

        // random phases across several geometries
        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                calm = 1'b1;
                set_geometry($urandom_range(1, 256), $urandom_range(1, 48));
            end
            else
                set_geometry(cols_plan[p], rows_plan[p]);
            queue_random((p == LONG_PHASE) ? LONG_ITEMS : PHASE_ITEMS, p == LONG_PHASE);
            drain();
        end

        if (commands_due.size() != 0)
        begin
            $error("%0d command beats never arrived", commands_due.size());
            errors++;
        end
        if (errors == 0)
            $display("utf8_text_console_cursor regression: pass");
        else
            $display("utf8_text_console_cursor regression: fail");
        $finish;
    end

endmodule
